// ===== src/rbd_pkg.sv =====
// Shared types and constants for the RGBA box downscaler.
// No dependencies; every other file in src imports this package.
`default_nettype none

package rbd_pkg;

  localparam int CH_W      = 8;   // one colour channel
  localparam int SUM_W     = 12;  // per-channel block sum, wraps at this width
  localparam int ROW_W     = 13;  // row_width register
  localparam int SCALE_W   = 2;   // scale_log2 register
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = ROW_W;
  localparam int Q_DEPTH   = 2;   // front-to-back queue entries

  localparam logic [ROW_W-1:0]   ROW_WIDTH_RST = 13'd4;
  localparam logic [SCALE_W-1:0] SCALE_RST     = 2'd0;
  localparam logic [SCALE_W-1:0] SCALE_MAX     = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_WIDTH  = 2'd0,
    CFG_SCALE_LOG2 = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic            start_of_frame;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_pix_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            row_end;
  } out_pix_t;

  // One classified pixel, as handed from the front to the back.
  typedef struct packed {
    logic               clr;      // first pixel of its block: overwrite the sum
    logic               emit;     // bottom-right pixel: produce a result
    logic               row_end;  // last whole block of the output row
    logic [SCALE_W-1:0] scale;    // effective log2 of the block size
    logic [CH_W-1:0]    r;
    logic [CH_W-1:0]    g;
    logic [CH_W-1:0]    b;
  } op_t;

  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } sum_t;

endpackage

`default_nettype wire

// ===== src/rgba_box_downscaler_top.sv =====
// Top level of the RGBA box downscaler: front, queue and back wired together.
// Depends on rbd_pkg, rbd_front, rbd_queue and rbd_back.
`default_nettype none

// Box-average downscaler for a raster RGB pixel stream. One pixel is taken per
// clock while in_ready is high; a result passes the queue, the block stage and
// the output register once the bottom-right pixel of its block is accepted.
// The rate is set by the column-sum line store, a single memory with one read
// and one write port, read and written once per pixel; back-to-back pixels of
// the same block are forwarded around it. After reset in_ready is low while the
// line store is cleared one entry per clock; cfg writes are taken at any time.
module rgba_box_downscaler_top #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rbd_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire rbd_pkg::in_pix_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output rbd_pkg::out_pix_t                   out_data
);
  import rbd_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int QW = AW + $bits(op_t);

  logic          push, pop, q_full, q_vld, clr_busy, cfg_wr;
  logic [AW-1:0] push_addr, q_addr;
  op_t           push_op, q_op;
  logic [QW-1:0] q_head;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  rbd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_full    (q_full),
    .clr_busy  (clr_busy),
    .in_ready  (in_ready),
    .push      (push),
    .push_addr (push_addr),
    .push_op   (push_op)
  );

  rbd_queue #(
    .DW (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_addr, push_op}),
    .pop       (pop),
    .head_vld  (q_vld),
    .head_data (q_head),
    .full      (q_full)
  );

  assign q_addr = q_head[QW-1 -: AW];
  assign q_op   = op_t'(q_head[$bits(op_t)-1:0]);

  rbd_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_addr    (q_addr),
    .q_op      (q_op),
    .pop       (pop),
    .clr_busy  (clr_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== src/rbd_queue.sv =====
// Short FIFO between the front and the back of the downscaler.
// Depends on rbd_pkg for its depth.
`default_nettype none

module rbd_queue #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  input  wire logic          pop,
  output logic               head_vld,
  output logic [DW-1:0]      head_data,
  output logic               full
);
  import rbd_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [DW-1:0]    store_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head_vld  = (cnt_r != '0);
  assign head_data = store_r[rd_ptr_r];
  assign full      = (cnt_r == CNT_W'(Q_DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/rbd_front.sv =====
// Front of the downscaler: configuration registers, raster position tracking
// and per-pixel classification into block operations. Depends on rbd_pkg.
`default_nettype none

module rbd_front #(
  parameter int MAX_WIDTH = 4096,
  parameter int AW        = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  input  wire logic [rbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rbd_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  wire logic                            in_valid,
  input  wire rbd_pkg::in_pix_t                in_data,
  input  wire logic                            q_full,
  input  wire logic                            clr_busy,
  output logic                                 in_ready,
  output logic                                 push,
  output logic [AW-1:0]                        push_addr,
  output rbd_pkg::op_t                         push_op
);
  import rbd_pkg::*;

  // position width: covers any programmed row width and MAX_WIDTH itself
  localparam int MW_W = $clog2(MAX_WIDTH + 1);
  localparam int PW   = (ROW_W > MW_W) ? ROW_W : MW_W;

  logic [ROW_W-1:0]   row_width_r;
  logic [SCALE_W-1:0] scale_r;
  logic [PW-1:0]      col_r, col_nxt;
  logic [1:0]         rib_r, rib_nxt;

  logic [PW-1:0]      w_raw, w_eff, blocks, col, bx, blocks_m1;
  logic [PW:0]        col_inc;
  logic [SCALE_W-1:0] s;
  logic [1:0]         fm, rib, lowbits;
  logic               in_range, fire;

  always_comb begin
    w_raw = PW'(row_width_r);
    if (w_raw == '0) begin
      w_eff = PW'(1);
    end else if (w_raw > PW'(MAX_WIDTH)) begin
      w_eff = PW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end

    s = (scale_r > SCALE_MAX) ? SCALE_MAX : scale_r;
    case (s)
      2'd0:    fm = 2'b00;
      2'd1:    fm = 2'b01;
      default: fm = 2'b11;
    endcase

    // start of frame restarts the position before this pixel is used
    col = in_data.start_of_frame ? '0 : col_r;
    rib = in_data.start_of_frame ? 2'b00 : (rib_r & fm);

    blocks    = w_eff >> s;
    blocks_m1 = blocks - 1'b1;
    bx        = col >> s;
    lowbits   = col[1:0] & fm;
    in_range  = (col < w_eff) && (bx < blocks);

    col_inc = {1'b0, col} + 1'b1;
    if (col_inc >= {1'b0, w_eff}) begin
      col_nxt = '0;
      rib_nxt = (rib + 1'b1) & fm;
    end else begin
      col_nxt = col_inc[PW-1:0];
      rib_nxt = rib;
    end
  end

  assign in_ready  = !clr_busy && !q_full;
  assign fire      = in_valid && in_ready;
  assign push      = fire && in_range;
  assign push_addr = bx[AW-1:0];

  always_comb begin
    push_op.clr     = (rib == 2'b00) && (lowbits == 2'b00);
    push_op.emit    = (rib == fm) && (lowbits == fm);
    push_op.row_end = (bx == blocks_m1);
    push_op.scale   = s;
    push_op.r       = in_data.red_in;
    push_op.g       = in_data.green_in;
    push_op.b       = in_data.blue_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
      scale_r     <= SCALE_RST;
      col_r       <= '0;
      rib_r       <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ROW_WIDTH:  row_width_r <= cfg_data;
          CFG_SCALE_LOG2: scale_r     <= cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (fire) begin
        col_r <= col_nxt;
        rib_r <= rib_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/rbd_back.sv =====
// Back of the downscaler: column-sum line store, read-modify-write with
// forwarding, averaging and the output register. Depends on rbd_pkg.
`default_nettype none

module rbd_back #(
  parameter int MAX_WIDTH = 4096,
  parameter int AW        = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_vld,
  input  wire logic [AW-1:0] q_addr,
  input  wire rbd_pkg::op_t  q_op,
  output logic               pop,
  output logic               clr_busy,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rbd_pkg::out_pix_t  out_data
);
  import rbd_pkg::*;

  sum_t          mem [MAX_WIDTH];

  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  logic          b_vld_r;
  logic [AW-1:0] b_addr_r;
  op_t           b_op_r;
  logic          fwd_r;
  sum_t          rd_data_r;
  sum_t          last_sum_r;

  logic          out_vld_r;
  out_pix_t      out_data_r;

  sum_t          base, sum;
  logic          b_adv, we, fwd_nxt;
  logic [AW-1:0] waddr;
  sum_t          wdata;

  function automatic logic [CH_W-1:0] avg(input logic [SUM_W-1:0] v,
                                          input logic [SCALE_W-1:0] sc);
    logic [CH_W-1:0] res;
    case (sc)
      2'd0:    res = v[CH_W-1:0];
      2'd1:    res = v[CH_W+1:2];
      default: res = v[CH_W+3:4];
    endcase
    return res;
  endfunction

  assign clr_busy  = clr_busy_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // hold the block stage only when it has a result and the output is blocked
  assign b_adv   = b_vld_r && (!b_op_r.emit || !out_vld_r || out_ready);
  assign pop     = q_vld && !clr_busy_r && (!b_vld_r || b_adv);
  // the entry read at this edge misses the write of the same edge: forward it
  assign fwd_nxt = b_adv && (b_addr_r == q_addr);

  always_comb begin
    base  = fwd_r ? last_sum_r : rd_data_r;
    sum.r = b_op_r.clr ? SUM_W'(b_op_r.r) : base.r + SUM_W'(b_op_r.r);
    sum.g = b_op_r.clr ? SUM_W'(b_op_r.g) : base.g + SUM_W'(b_op_r.g);
    sum.b = b_op_r.clr ? SUM_W'(b_op_r.b) : base.b + SUM_W'(b_op_r.b);

    we    = clr_busy_r || b_adv;
    waddr = clr_busy_r ? clr_addr_r : b_addr_r;
    wdata = clr_busy_r ? sum_t'('0) : sum;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (pop) begin
      rd_data_r <= mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      b_vld_r    <= 1'b0;
      fwd_r      <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        if (clr_addr_r == AW'(MAX_WIDTH - 1)) begin
          clr_busy_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + 1'b1;
        end
      end
      if (pop) begin
        b_vld_r <= 1'b1;
        fwd_r   <= fwd_nxt;
      end else if (b_adv) begin
        b_vld_r <= 1'b0;
      end
      if (b_adv && b_op_r.emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_addr_r <= q_addr;
      b_op_r   <= q_op;
    end
    if (b_adv) begin
      last_sum_r <= sum;
    end
    if (b_adv && b_op_r.emit) begin
      out_data_r.red_out   <= avg(sum.r, b_op_r.scale);
      out_data_r.green_out <= avg(sum.g, b_op_r.scale);
      out_data_r.blue_out  <= avg(sum.b, b_op_r.scale);
      out_data_r.row_end   <= b_op_r.row_end;
    end
  end

endmodule

`default_nettype wire
